[sv/histeq_pkg.sv]
// histeq_pkg: shared constants and types for the histogram equalizer.
// No dependencies.
`timescale 1ns / 1ps

package histeq_pkg;
    localparam int BINS_DEF     = 256;
    localparam int CHANNELS_DEF = 3;
    localparam int PIX_BITS_DEF = 22;
    localparam int VAL_W        = 8;

    typedef enum logic [1:0] {
        ACT_COUNT = 2'd0,
        ACT_MAP   = 2'd1,
        ACT_START = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [0:0] REG_COLOR_MODE = 1'b0;
endpackage

[sv/histogram_equalizer.sv]
// Histogram equalizer top level: counting, map build and lookup under one sequencer.
// Depends on histeq_pkg.
`timescale 1ns / 1ps

// Two-pass histogram equalizer for 8-bit grey or three-channel pixels. The
// action travels in s_tuser: 0 counts a pixel, 1 maps a pixel (one result),
// 2 starts a new frame. One item is taken at a time. A count does a
// read-modify-write of the bin memories, a map a registered map lookup, and
// a start runs a clearing pass over the bin memories, one bin a cycle.
// After reset the same clearing pass runs before the first item is accepted.
// The first map after any count or start builds the maps: the shared divider
// walks bins 0..255 per channel, a bin read, one cumulative sum, then a
// (PIXEL_COUNT_BITS+8)-step restoring division and a write per bin, all
// before the usual map lookup.
// With no pixels counted every map entry is 0.
module histogram_equalizer #(
    parameter int CHANNELS         = histeq_pkg::CHANNELS_DEF,
    parameter int PIXEL_COUNT_BITS = histeq_pkg::PIX_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] action
    input  logic [23:0] s_tdata,   // [7:0] chan0_in, [15:8] chan1_in, [23:16] chan2_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] chan0_out, [15:8] chan1_out, [23:16] chan2_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int PB   = PIXEL_COUNT_BITS;
    localparam int CW   = PB;             // bin count width
    localparam int NW   = PB + 8;         // numerator 255*cum width
    localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STW  = $clog2(NW + 1);
    localparam logic [PB-1:0] COUNT_MAX = {PB{1'b1}};

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_CNT   = 8'b0000_0100,
        S_BRD   = 8'b0000_1000,
        S_BACC  = 8'b0001_0000,
        S_BDIV  = 8'b0010_0000,
        S_MRD   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] bin_mem [CHANNELS][256];
    logic [7:0]    map_mem [CHANNELS][256];
    logic [CW-1:0] bin_q [CHANNELS];
    logic [7:0]    map_q [CHANNELS];

    logic          color_mode_reg;
    logic [PB-1:0] total_reg;
    logic          ready_reg;
    logic [7:0]    idx_reg;
    logic [CHW-1:0] ch_reg;
    logic [7:0]    val_reg [3];
    logic [PB-1:0] cum_reg;
    logic [NW-1:0] num_reg;
    logic [PB:0]   rem_reg;
    logic [7:0]    quo_reg;
    logic [STW-1:0] step_reg;
    logic [23:0]   out_reg;
    logic          mvalid_reg;

    logic s_fire, m_fire, out_free;
    histeq_pkg::action_t act;

    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign out_free = !mvalid_reg || m_tready;
    assign act      = histeq_pkg::action_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = out_reg;
    assign pready   = 1'b1;
    assign prdata   = {31'd0, color_mode_reg};

    function automatic logic used(input int c, input logic mode);
        used = (c < CHANNELS) && (c == 0 || mode);
    endfunction

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (idx_reg == 8'hFF) state_next = S_IDLE;
            S_IDLE: if (s_fire) begin
                priority case (act)
                    histeq_pkg::ACT_COUNT:
                        if (total_reg != COUNT_MAX) state_next = S_CNT;
                    histeq_pkg::ACT_START: state_next = S_CLEAR;
                    histeq_pkg::ACT_MAP: state_next = ready_reg ? S_MRD : S_BRD;
                    default: state_next = S_IDLE;
                endcase
            end
            S_CNT:  state_next = S_IDLE;
            S_BRD:  state_next = S_BACC;
            S_BACC: state_next = S_BDIV;
            S_BDIV: if (step_reg == STW'(NW)) begin
                if (idx_reg == 8'hFF && 32'(ch_reg) == CHANNELS - 1) state_next = S_MRD;
                else state_next = S_BRD;
            end
            S_MRD:  state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // bin and map memories: one write port and one read port each, registered read
    always_ff @(posedge aclk) begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (state_reg == S_CLEAR)
                bin_mem[c][idx_reg] <= '0;
            else if (state_reg == S_CNT && (c == 0 || color_mode_reg))
                bin_mem[c][val_reg[c]] <= bin_q[c] + CW'(1);
            if (state_reg == S_BDIV && step_reg == STW'(NW) && 32'(ch_reg) == c)
                map_mem[c][idx_reg] <= quo_reg;
            if (state_reg == S_IDLE && s_fire)
                bin_q[c] <= bin_mem[c][s_tdata[8*c +: 8]];
            else
                bin_q[c] <= bin_mem[c][idx_reg];
            map_q[c] <= map_mem[c][val_reg[c]];
        end
    end

    // shared restoring divider: quotient bits of num / total, one per cycle
    logic [PB:0] trial;
    assign trial = {rem_reg[PB-1:0], num_reg[NW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            ch_reg         <= '0;
            color_mode_reg <= 1'b1;
            total_reg      <= '0;
            ready_reg      <= 1'b0;
            mvalid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free) mvalid_reg <= 1'b1;
            else if (m_fire) mvalid_reg <= 1'b0;
            if (psel && penable && pwrite && paddr == histeq_pkg::REG_COLOR_MODE)
                color_mode_reg <= pwdata[0];
            unique case (state_reg)
                S_CLEAR: idx_reg <= idx_reg + 8'd1;
                S_IDLE: if (s_fire) begin
                    for (int c = 0; c < 3; c++) val_reg[c] <= s_tdata[8*c +: 8];
                    idx_reg <= '0;
                    ch_reg  <= '0;
                    cum_reg <= '0;
                    if (act == histeq_pkg::ACT_START) begin
                        total_reg <= '0;
                        ready_reg <= 1'b0;
                    end
                    if (act == histeq_pkg::ACT_COUNT && total_reg != COUNT_MAX) begin
                        total_reg <= total_reg + PB'(1);
                        ready_reg <= 1'b0;
                    end
                end
                S_CNT: ;
                S_BRD: ;
                S_BACC: begin
                    num_reg  <= {cum_reg + bin_q[ch_reg], 8'd0} - NW'(cum_reg + bin_q[ch_reg]);
                    cum_reg  <= cum_reg + bin_q[ch_reg];
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    step_reg <= '0;
                end
                S_BDIV: begin
                    if (step_reg == STW'(NW)) begin
                        idx_reg <= idx_reg + 8'd1;
                        if (idx_reg == 8'hFF) begin
                            ch_reg  <= ch_reg + CHW'(1);
                            cum_reg <= '0;
                        end
                        if (state_next == S_MRD) ready_reg <= 1'b1;
                    end else begin
                        step_reg <= step_reg + STW'(1);
                        num_reg  <= num_reg << 1;
                        if (total_reg != '0 && trial >= {1'b0, total_reg}) begin
                            rem_reg <= trial - {1'b0, total_reg};
                            quo_reg <= {quo_reg[6:0], 1'b1};
                        end else begin
                            rem_reg <= trial;
                            quo_reg <= {quo_reg[6:0], 1'b0};
                        end
                    end
                end
                S_MRD: ;
                S_OUT: if (out_free) begin
                    for (int c = 0; c < 3; c++)
                        out_reg[8*c +: 8] <= used(c, color_mode_reg) ? map_q[c < CHANNELS ? c : 0]
                                                                      : 8'd0;
                end
                default: ;
            endcase
        end
    end

    // assertions
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready) else $error("accept while busy");
    a_out_after_map: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mvalid_reg) |-> $past(state_reg) == S_OUT) else $error("stray result");
    a_total_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(total_reg) == COUNT_MAX && $past(state_reg) != S_CLEAR) |->
        (total_reg == COUNT_MAX || total_reg == '0)) else $error("count wrapped");
endmodule

[dv/histeq_checker.sv]
// histeq_checker: watches the pixel, result and register ports of the
// histogram equalizer, predicts each result and compares. Depends on histeq_pkg.
`timescale 1ns / 1ps

module histeq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [7:0] c2;
        logic [7:0] c1;
        logic [7:0] c0;
    } pixel_t;

    int         hist [3][256];
    logic [7:0] lut  [3][256];
    int         pixel_total;
    bit         lut_valid;
    bit         color_mode;
    pixel_t     expected_pixels [$];

    function automatic bit chan_on(int c);
        return c == 0 || color_mode;
    endfunction

    task automatic build_luts();
        longint cum;
        longint q;
        for (int c = 0; c < 3; c++) begin
            cum = 0;
            for (int v = 0; v < 256; v++) begin
                cum += hist[c][v];
                q = (pixel_total == 0) ? 0 : (255 * cum) / pixel_total;
                if (q > 255) q = 255;
                lut[c][v] = q[7:0];
            end
        end
        lut_valid = 1;
    endtask

    task automatic take_item(logic [1:0] u, logic [23:0] d);
        histeq_pkg::action_t act;
        logic [7:0] v [3];
        pixel_t     p;
        act  = histeq_pkg::action_t'(u);
        v[0] = d[7:0];
        v[1] = d[15:8];
        v[2] = d[23:16];
        case (act)
            histeq_pkg::ACT_COUNT: begin
                if (pixel_total < (1 << histeq_pkg::PIX_BITS_DEF) - 1) begin
                    for (int c = 0; c < 3; c++)
                        if (chan_on(c)) hist[c][v[c]]++;
                    pixel_total++;
                    lut_valid = 0;
                end
            end
            histeq_pkg::ACT_START: begin
                foreach (hist[c, b]) hist[c][b] = 0;
                pixel_total = 0;
                lut_valid = 0;
            end
            histeq_pkg::ACT_MAP: begin
                if (!lut_valid) build_luts();
                p.c0 = lut[0][v[0]];
                p.c1 = chan_on(1) ? lut[1][v[1]] : 8'd0;
                p.c2 = chan_on(2) ? lut[2][v[2]] : 8'd0;
                expected_pixels = {expected_pixels, p};
            end
            default: ;
        endcase
    endtask

    task automatic check_result(pixel_t got);
        pixel_t exp_p;
        if (expected_pixels.size() == 0) begin
            $error("unexpected result transfer %h", got);
            fail_count++;
            return;
        end
        exp_p = expected_pixels.pop_front();
        if (got.c0 !== exp_p.c0) begin
            $error("chan0_out expected %0d actual %0d", exp_p.c0, got.c0);
            fail_count++;
        end
        if (got.c1 !== exp_p.c1) begin
            $error("chan1_out expected %0d actual %0d", exp_p.c1, got.c1);
            fail_count++;
        end
        if (got.c2 !== exp_p.c2) begin
            $error("chan2_out expected %0d actual %0d", exp_p.c2, got.c2);
            fail_count++;
        end
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (hist[c, b]) hist[c][b] = 0;
            pixel_total = 0;
            lut_valid = 0;
            color_mode = 1;
            expected_pixels.delete();
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (s_tvalid && s_tready) take_item(s_tuser, s_tdata);
            if (psel && penable && pwrite && pready && paddr == histeq_pkg::REG_COLOR_MODE)
                color_mode = pwdata[0];
        end
        pending <= expected_pixels.size();
    end

    final begin
        if (expected_pixels.size() != 0) $error("%0d results never arrived",
                                                expected_pixels.size());
    end
endmodule

[dv/histogram_equalizer_test.sv]
// histogram_equalizer_test: clock, reset, pixel stimulus, register writes and
// the verdict. Depends on histeq_pkg, histogram_equalizer and histeq_checker.
`timescale 1ns / 1ps

module histogram_equalizer_test;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int idle_mode = 0;   // 0 none, 1 sender 46%, 2 receiver 46%, 3 both 6%
    int rx_hold = 0;
    int sent = 0;

    histogram_equalizer u_top (.*);

    histeq_checker u_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tuser, .s_tdata, .m_tvalid,
        .m_tready, .m_tdata, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fail_count, .pending
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // receiver side: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 0;
        end else if (idle_mode == 2) begin
            m_tready <= $urandom_range(99) >= 46;
        end else if (idle_mode == 3) begin
            m_tready <= $urandom_range(99) >= 6;
        end else begin
            m_tready <= 1;
        end
    end

    task automatic send_pixel(histeq_pkg::action_t act, logic [7:0] c0, logic [7:0] c1,
                              logic [7:0] c2);
        int pct;
        pct = (idle_mode == 1) ? 46 : (idle_mode == 3) ? 6 : 0;
        while ($urandom_range(99) < pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= act;
        s_tdata  <= {c2, c1, c0};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic rand_pixel(histeq_pkg::action_t act);
        send_pixel(act, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
    endtask

    // stop sending and wait until every result is out and the block is idle
    task automatic wait_idle();
        s_tvalid <= 0;
        do @(posedge aclk); while (pending != 0 || !s_tready);
    endtask

    task automatic set_color_mode(bit mode);
        wait_idle();
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= histeq_pkg::REG_COLOR_MODE;
        pwdata <= {31'd0, mode};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(posedge aclk);
    endtask

    initial begin
        int n_count;
        int n_map;
        int frame;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty histogram, extremes, both modes, unused action
        send_pixel(histeq_pkg::ACT_MAP, 8'd0, 8'd255, 8'd128);
        send_pixel(histeq_pkg::ACT_START, 8'd0, 8'd0, 8'd0);
        send_pixel(histeq_pkg::ACT_MAP, 8'd255, 8'd255, 8'd255);
        send_pixel(histeq_pkg::ACT_COUNT, 8'd0, 8'd0, 8'd0);
        send_pixel(histeq_pkg::ACT_COUNT, 8'd255, 8'd255, 8'd255);
        send_pixel(histeq_pkg::ACT_COUNT, 8'd0, 8'd255, 8'd170);
        send_pixel(histeq_pkg::ACT_NONE, 8'd85, 8'd85, 8'd85);
        send_pixel(histeq_pkg::ACT_MAP, 8'd0, 8'd0, 8'd0);
        send_pixel(histeq_pkg::ACT_MAP, 8'd255, 8'd255, 8'd255);
        send_pixel(histeq_pkg::ACT_MAP, 8'd254, 8'd1, 8'd170);
        set_color_mode(0);
        send_pixel(histeq_pkg::ACT_MAP, 8'd0, 8'd255, 8'd255);
        send_pixel(histeq_pkg::ACT_COUNT, 8'd0, 8'd77, 8'd99);
        send_pixel(histeq_pkg::ACT_MAP, 8'd0, 8'd0, 8'd0);
        send_pixel(histeq_pkg::ACT_MAP, 8'd255, 8'd255, 8'd255);
        send_pixel(histeq_pkg::ACT_START, 8'd255, 8'd255, 8'd255);
        send_pixel(histeq_pkg::ACT_COUNT, 8'd255, 8'd0, 8'd0);
        send_pixel(histeq_pkg::ACT_MAP, 8'd255, 8'd255, 8'd255);
        set_color_mode(1);
        send_pixel(histeq_pkg::ACT_MAP, 8'd255, 8'd0, 8'd0);

        frame = 0;
        while (sent < 1750) begin
            idle_mode = frame % 4;
            if (frame % 5 == 4) set_color_mode(1'($urandom_range(1)));
            if ($urandom_range(9) != 0) rand_pixel(histeq_pkg::ACT_START);
            n_count = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 60);
            repeat (n_count) rand_pixel(histeq_pkg::ACT_COUNT);
            if (frame == 2) rx_hold = 500;
            n_map = $urandom_range(40, 100);
            repeat (n_map) begin
                case ($urandom_range(199))
                    0:       rand_pixel(histeq_pkg::ACT_COUNT);
                    1, 2, 3: rand_pixel(histeq_pkg::ACT_NONE);
                    default: rand_pixel(histeq_pkg::ACT_MAP);
                endcase
            end
            if (frame == 5) begin
                wait_idle();
                @(posedge aclk);
            end
            frame++;
        end
        idle_mode = 0;

        wait_idle();
        repeat (300) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
